### rtl/class_vote_stabilizer_defines.svh
// ----------------------------------------------------------------------------
// class_vote_stabilizer_defines.svh
// Assertion macros shared by the class vote stabilizer RTL.
// ----------------------------------------------------------------------------
`ifndef CLASS_VOTE_STABILIZER_DEFINES_SVH
`define CLASS_VOTE_STABILIZER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset
`define CVS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define CVS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CVS_ASSERT(label, clk, rst, prop, msg)
`define CVS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants of the class vote stabilizer.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // Default configuration of the block
  localparam int NUM_CLASSES_DEF   = 16;
  localparam int COUNTER_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 5;
  localparam int CLASS_W   = 4;

  // Register reset values
  localparam logic [CFG_W-1:0] FLOOR_RST     = 8'd0;
  localparam logic [CFG_W-1:0] CEILING_RST   = 8'd10;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR     = 2'd0,
    REG_CEILING   = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic start;   // transaction accepted, capture measured class
    logic proc;    // read data of proc_idx is on the RAM output
    logic first;   // proc is for entry zero
    logic load;    // load the result register
  } ctrl_t;

endpackage

### rtl/cvs_ram.sv
// ----------------------------------------------------------------------------
// cvs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cvs_ctrl.sv
// ----------------------------------------------------------------------------
// cvs_ctrl
// Sequencer: accepts a transaction, walks the counter RAM in index order and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
`include "class_vote_stabilizer_defines.svh"

module cvs_ctrl import cvs_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           out_free,
  output logic                           rd_en,
  output logic [$clog2(NUM_CLASSES)-1:0] rd_addr,
  output logic [$clog2(NUM_CLASSES)-1:0] proc_idx,
  output ctrl_t                          ctrl
);

  localparam int AW = $clog2(NUM_CLASSES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CLASSES - 1);

  state_t        state, state_next;
  logic [AW-1:0] addr, addr_next;
  logic          proc, first;

  // Next state and read address
  always_comb begin
    state_next = state;
    addr_next  = addr;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (LAST_IDX == '0) ? ST_DRAIN : ST_WALK;
          addr_next  = AW'(1);
        end
      end
      ST_WALK: begin
        addr_next = addr + AW'(1);
        if (addr == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer; hold the input stalled during reset
  always_comb begin
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = addr;
    ctrl.start = 1'b0;
    ctrl.load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall   = rst;
        rd_en      = in_valid;
        rd_addr    = '0;
        ctrl.start = in_valid;
      end
      ST_WALK: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        rd_en = 1'b0;
      end
      ST_FINISH: begin
        ctrl.load = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    ctrl.proc  = proc;
    ctrl.first = first;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
      proc  <= 1'b0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
      proc  <= rd_en;
    end
  end

  // Track which entry the RAM output belongs to
  always_ff @(posedge clk) begin
    proc_idx <= rd_addr;
    first    <= (rd_addr == '0);
  end

  `CVS_ASSERT(a_no_rw_collision, clk, rst, (rd_en && proc) |-> (rd_addr != proc_idx), "read and write-back hit one entry")
  `CVS_ASSERT(a_accept_starts_walk, clk, rst, (in_valid && !in_stall) |=> (proc && first), "accepted transaction did not read entry zero")
  `CVS_ASSERT(a_last_then_finish, clk, rst, (proc && (proc_idx == LAST_IDX)) |=> (state == ST_FINISH), "last write-back not followed by finish")

endmodule

### rtl/cvs_dp.sv
// ----------------------------------------------------------------------------
// cvs_dp
// Datapath: saturating counter update, threshold crossings, running maximum
// and the result register.
// ----------------------------------------------------------------------------
`include "class_vote_stabilizer_defines.svh"

module cvs_dp import cvs_pkg::*; #(
  parameter int NUM_CLASSES   = NUM_CLASSES_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_t                          ctrl,
  input  logic [$clog2(NUM_CLASSES)-1:0] proc_idx,
  input  logic [IN_W-1:0]                measured_class,
  input  logic [COUNTER_WIDTH-1:0]       floor_lim,
  input  logic [COUNTER_WIDTH-1:0]       ceil_lim,
  input  logic [CFG_W-1:0]               threshold,
  input  logic [COUNTER_WIDTH-1:0]       rd_data,
  output logic                           wr_en,
  output logic [$clog2(NUM_CLASSES)-1:0] wr_addr,
  output logic [COUNTER_WIDTH-1:0]       wr_data,
  input  logic                           out_stall,
  output logic                           out_free,
  output logic                           out_valid,
  output logic                           winner_valid,
  output logic [CLASS_W-1:0]             winner_class,
  output logic                           active_flag
);

  localparam int AW   = $clog2(NUM_CLASSES);
  localparam int CW   = COUNTER_WIDTH;
  localparam int TW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int EW   = (AW > IN_W) ? AW : IN_W;
  localparam int WIDX = (AW > CLASS_W) ? AW : CLASS_W;

  logic [IN_W-1:0]        meas_q;
  logic [NUM_CLASSES-1:0] vld;
  logic                   active;
  logic [CW-1:0]          best;
  logic [AW-1:0]          best_idx;

  logic [CW-1:0]   cnt_cur, cnt_new, cnt_up, cnt_down;
  logic [CW:0]     cnt_inc;
  logic            is_meas, cnt_ge, best_gt;
  logic [WIDX-1:0] idx_ext;

  // Capture the measured class of the accepted transaction
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      meas_q <= measured_class;
    end
  end

  // Saturating update of the entry on the RAM output
  always_comb begin
    cnt_cur  = vld[proc_idx] ? rd_data : '0;
    cnt_inc  = {1'b0, cnt_cur} + (CW + 1)'(1);
    cnt_up   = (cnt_inc > {1'b0, ceil_lim}) ? ceil_lim : cnt_inc[CW-1:0];
    cnt_down = (cnt_cur <= floor_lim) ? floor_lim : cnt_cur - CW'(1);
    is_meas  = (EW'(meas_q) == EW'(proc_idx));
    cnt_new  = is_meas ? cnt_up : cnt_down;
    cnt_ge   = (TW'(cnt_new) >= TW'(threshold));
  end

  assign wr_en   = ctrl.proc;
  assign wr_addr = proc_idx;
  assign wr_data = cnt_new;

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.proc) begin
      vld[proc_idx] <= 1'b1;
    end
  end

  // Set the flag when the measured counter reaches threshold, clear it when another counter is below it
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.proc) begin
      if (is_meas && cnt_ge) begin
        active <= 1'b1;
      end else if (!is_meas && !cnt_ge) begin
        active <= 1'b0;
      end
    end
  end

  // Keep the first index holding the largest counter
  always_ff @(posedge clk) begin
    if (ctrl.proc && (ctrl.first || (cnt_new > best))) begin
      best     <= cnt_new;
      best_idx <= proc_idx;
    end
  end

  assign best_gt = (TW'(best) > TW'(threshold));
  assign idx_ext = WIDX'(best_idx);
  assign out_free = !out_valid || !out_stall;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      winner_valid <= best_gt;
      winner_class <= best_gt ? idx_ext[CLASS_W-1:0] : '0;
      active_flag  <= active;
    end
  end

  `CVS_ASSERT(a_load_when_free, clk, rst, ctrl.load |-> (!out_valid || !out_stall), "result loaded over a pending transaction")
  `CVS_ASSERT(a_meas_sets_active, clk, rst, (ctrl.proc && is_meas && cnt_ge) |=> active, "crossing by measured class did not set flag")
  `CVS_ASSERT(a_class_zero_invalid, clk, rst, (out_valid && !winner_valid) |-> (winner_class == '0), "winner class nonzero without winner")

endmodule

### rtl/class_vote_stabilizer.sv
// ----------------------------------------------------------------------------
// class_vote_stabilizer
// Smooths per-frame class decisions with one saturating counter per class.
// ----------------------------------------------------------------------------
// The counters live in a RAM with one read and one write port. For each input
// transaction the sequencer reads one counter per cycle, writes it back updated
// on the next cycle, then loads the result register once it is free. in_stall
// stays high while a transaction is walked; a finished result waits in the
// output register while the next transaction is taken. The counters come out
// of reset at zero through per-entry valid bits, so no clearing pass is
// needed. Configuration writes are taken at any time outside reset and should
// be issued only while the block is idle.
`include "class_vote_stabilizer_defines.svh"

module class_vote_stabilizer import cvs_pkg::*; #(
  parameter int NUM_CLASSES   = NUM_CLASSES_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      measured_class,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 winner_valid,
  output logic [CLASS_W-1:0]   winner_class,
  output logic                 active_flag,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(NUM_CLASSES);
  localparam int CW = COUNTER_WIDTH;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [LW-1:0] CNT_MAX = LW'((1 << CW) - 1);

  logic [CFG_W-1:0] floor_q, ceil_q, thresh_q;
  logic [LW-1:0]    floor_ext, ceil_ext;
  logic [CW-1:0]    floor_lim, ceil_lim;

  ctrl_t         ctrl;
  logic          rd_en, wr_en, out_free;
  logic [AW-1:0] rd_addr, proc_idx, wr_addr;
  logic [CW-1:0] rd_data, wr_data;

  assign cfg_ready = !rst;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_q  <= FLOOR_RST;
      ceil_q   <= CEILING_RST;
      thresh_q <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FLOOR:     floor_q  <= cfg_data;
        REG_CEILING:   ceil_q   <= cfg_data;
        REG_THRESHOLD: thresh_q <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Limit floor and ceiling to the counter range
  always_comb begin
    floor_ext = LW'(floor_q);
    ceil_ext  = LW'(ceil_q);
    floor_lim = (floor_ext > CNT_MAX) ? CNT_MAX[CW-1:0] : floor_ext[CW-1:0];
    ceil_lim  = (ceil_ext > CNT_MAX) ? CNT_MAX[CW-1:0] : ceil_ext[CW-1:0];
  end

  cvs_ctrl #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .proc_idx (proc_idx),
    .ctrl     (ctrl)
  );

  cvs_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_CLASSES)
  ) u_counters (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cvs_dp #(
    .NUM_CLASSES   (NUM_CLASSES),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .proc_idx       (proc_idx),
    .measured_class (measured_class),
    .floor_lim      (floor_lim),
    .ceil_lim       (ceil_lim),
    .threshold      (thresh_q),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_stall      (out_stall),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .winner_valid   (winner_valid),
    .winner_class   (winner_class),
    .active_flag    (active_flag)
  );

  `CVS_ASSERT(a_limits_in_range, clk, rst, (LW'(floor_lim) <= CNT_MAX) && (LW'(ceil_lim) <= CNT_MAX), "limit outside counter range")
  `CVS_ASSERT(a_no_accept_with_result_load, clk, rst, ctrl.load |-> in_stall, "transaction accepted while loading result")
  `CVS_ASSERT_ALWAYS(a_reset_out_idle, clk, rst |=> !out_valid, "result valid right after reset")

endmodule
